FILE: hw/rtl/bcf_pkg.sv
package bcf_pkg;

   // x86 near CALL / JMP opcodes
   localparam logic [7:0] OP_CALL   = 8'hE8;
   localparam logic [7:0] OP_JMP    = 8'hE9;

   // history mask handling
   localparam logic [7:0] HIST_KEEP = 8'h77;
   localparam logic [7:0] HIST_MSB  = 8'h10;

   // probe byte select, indexed by mask bits [3:1]
   localparam logic [1:0] BIT_NUMBER [8] = '{2'd0, 2'd1, 2'd2, 2'd2,
                                             2'd3, 2'd3, 2'd3, 2'd3};
   // allowed mask states, bit i for mask bits [3:1] == i
   localparam logic [7:0] ALLOWED_STATUS = 8'b0001_0111;

   // register indexes
   localparam logic CSR_DIRECTION      = 1'b0;
   localparam logic CSR_START_POSITION = 1'b1;

   typedef struct packed {
      logic        direction;      // 1 encode, 0 decode
      logic [31:0] operand;        // little-endian operand after the opcode
      logic [31:0] position;       // stream position of the opcode
      logic [2:0]  distance;       // bytes since previous opcode, saturated at 6
      logic [7:0]  mask_history;
   } bcf_conv_query_type;

   typedef struct packed {
      logic        take;           // operand gets rewritten
      logic [31:0] dest;           // rewritten operand
      logic [7:0]  reject_mask;    // history mask if the opcode is rejected
   } bcf_conv_result_type;

   // sign-extension byte test
   function automatic logic ms_byte(logic [7:0] value);
      return (value == 8'h00) || (value == 8'hFF);
   endfunction

endpackage

FILE: hw/rtl/bcf_convert.sv
module bcf_convert (
   input  bcf_pkg::bcf_conv_query_type  query,
   output bcf_pkg::bcf_conv_result_type result
);
   import bcf_pkg::*;

   logic [7:0]  mask;
   logic [1:0]  sel;
   logic [4:0]  probe_shift;
   logic [31:0] flip;
   logic [31:0] k;
   logic [31:0] dest0, dest1, dest2;
   logic [31:0] src1, src2;
   logic [7:0]  probe0, probe1;

   always_comb begin
      // age the history mask by the distance since the previous opcode
      mask = query.mask_history;
      for (int s = 0; s < 5; s++) begin
         if (3'(s) < query.distance) begin
            mask = (mask & HIST_KEEP) << 1;
         end
      end
      if (query.distance > 3'd5) begin
         mask = '0;
      end

      sel         = BIT_NUMBER[mask[3:1]];
      probe_shift = 5'd24 - {sel, 3'b000};
      flip        = 32'hFFFF_FFFF >> {sel, 3'b000};
      k           = query.position + 32'd5;

      // up to three tries; the retry alternates, so the third value is final
      dest0  = query.direction ? query.operand + k : query.operand - k;
      probe0 = 8'(dest0 >> probe_shift);
      src1   = dest0 ^ flip;
      dest1  = query.direction ? src1 + k : src1 - k;
      probe1 = 8'(dest1 >> probe_shift);
      src2   = dest1 ^ flip;
      dest2  = query.direction ? src2 + k : src2 - k;

      if ((mask == 8'h00) || !ms_byte(probe0)) begin
         result.dest = dest0;
      end else if (!ms_byte(probe1)) begin
         result.dest = dest1;
      end else begin
         result.dest = dest2;
      end

      result.take = ms_byte(query.operand[31:24]) && ALLOWED_STATUS[mask[3:1]]
                    && (mask[7:5] == 3'b000);
      result.reject_mask = mask | 8'h01
                           | (ms_byte(query.operand[31:24]) ? HIST_MSB : 8'h00);
   end

endmodule

FILE: hw/rtl/x86_branch_call_filter_core.sv
// x86 branch/call (BCJ) filter. Bytes of a code stream enter on req_, one per
// transfer, and leave in stream order on rsp_. Every E8/E9 opcode whose
// operand passes the history-mask and sign-byte tests has its 32-bit operand
// rewritten: relative to absolute with direction = 1, back with direction = 0.
// An opcode in the last four bytes of a stream (marked by req_tlast) is not
// converted and rsp_tlast marks the final byte out. Rate: one byte per cycle
// while the result port is not stalled and each byte releases at most one
// result, which is the steady state. A converted instruction releases five
// bytes at once and a stream end up to five; the result port moves one byte
// per transfer out of a five-entry result buffer, so input then holds until
// the buffer drains (after a conversion the next four bytes only refill the
// window). A byte passes through the input register, then the window logic
// into the result buffer. Configure only while idle; a start_position write
// before the first byte of a stream also loads the stream position.
module x86_branch_call_filter_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // out_last

   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import bcf_pkg::*;

   // configuration
   logic        direction_ff;
   logic [31:0] start_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // stream state
   logic [7:0]  win_ff [5];
   logic [7:0]  win_in [5];
   logic [2:0]  fill_ff,  fill_in;
   logic [31:0] pos_ff,   pos_in;
   logic [2:0]  dist_ff,  dist_in;
   logic [7:0]  mask_ff,  mask_in;
   logic        in_stream_ff;

   // result buffer, head at entry 0
   logic [7:0]  obuf_ff [5];
   logic [7:0]  obuf_in [5];
   logic [2:0]  ocnt_ff,  ocnt_in;
   logic        olast_ff;

   logic [7:0]  w [5];      // window with the new byte placed
   logic        pop;
   logic        step;
   logic        full;       // window reaches five bytes, head is inspected
   logic        opcode;
   logic        conv;

   bcf_conv_query_type  query;
   bcf_conv_result_type result;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (ocnt_ff != 3'd0);
   assign rsp_tdata  = obuf_ff[0];
   assign rsp_tlast  = olast_ff && (ocnt_ff == 3'd1);

   // step only into a buffer that is empty after this cycle's transfer
   assign step       = in_valid_ff && ((ocnt_ff - {2'b00, pop}) == 3'd0);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         w[i] = (3'(i) == fill_ff) ? in_byte_ff : win_ff[i];
      end
   end

   assign full   = (fill_ff == 3'd4);
   assign opcode = (w[0] == OP_CALL) || (w[0] == OP_JMP);

   assign query.direction    = direction_ff;
   assign query.operand      = {w[4], w[3], w[2], w[1]};
   assign query.position     = pos_ff;
   assign query.distance     = dist_ff;
   assign query.mask_history = mask_ff;

   bcf_convert u_convert (
      .query  (query),
      .result (result)
   );

   assign conv = full && opcode && result.take;

   // next stream state
   always_comb begin
      win_in  = w;
      fill_in = fill_ff + 3'd1;
      pos_in  = pos_ff;
      dist_in = dist_ff;
      mask_in = mask_ff;
      if (in_last_ff) begin
         fill_in = 3'd0;
         pos_in  = start_ff;
         dist_in = 3'd6;
         mask_in = 8'h00;
      end else if (conv) begin
         fill_in = 3'd0;
         pos_in  = pos_ff + 32'd5;
         dist_in = 3'd5;
         mask_in = 8'h00;
      end else if (full) begin
         for (int i = 0; i < 4; i++) begin
            win_in[i] = w[i + 1];
         end
         fill_in = 3'd4;
         pos_in  = pos_ff + 32'd1;
         if (opcode) begin
            dist_in = 3'd1;
            mask_in = result.reject_mask;
         end else if (dist_ff < 3'd6) begin
            dist_in = dist_ff + 3'd1;
         end
      end
   end

   // result buffer: load on a step, else shift out on a transfer
   always_comb begin
      obuf_in = obuf_ff;
      ocnt_in = ocnt_ff - {2'b00, pop};
      for (int i = 0; i < 4; i++) begin
         if (pop) begin
            obuf_in[i] = obuf_ff[i + 1];
         end
      end
      if (step) begin
         if (conv) begin
            obuf_in[0] = w[0];
            obuf_in[1] = result.dest[7:0];
            obuf_in[2] = result.dest[15:8];
            obuf_in[3] = result.dest[23:16];
            obuf_in[4] = result.dest[24] ? 8'hFF : 8'h00;
            ocnt_in    = 3'd5;
         end else begin
            obuf_in = w;
            if (in_last_ff) begin
               ocnt_in = fill_ff + 3'd1;   // everything held flushes unchanged
            end else if (full) begin
               ocnt_in = 3'd1;
            end else begin
               ocnt_in = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         start_ff     <= '0;
         in_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         dist_ff      <= 3'd6;
         mask_ff      <= '0;
         in_stream_ff <= 1'b0;
         ocnt_ff      <= '0;
         olast_ff     <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_DIRECTION: begin
                  direction_ff <= csr_wdata[0];
               end
               CSR_START_POSITION: begin
                  start_ff <= csr_wdata;
                  if (!in_stream_ff) begin
                     pos_ff <= csr_wdata;
                  end
               end
               default: begin
               end
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            fill_ff      <= fill_in;
            pos_ff       <= pos_in;
            dist_ff      <= dist_in;
            mask_ff      <= mask_in;
            in_stream_ff <= !in_last_ff;
            olast_ff     <= in_last_ff;
         end
         ocnt_ff <= ocnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step) begin
         win_ff <= win_in;
      end
      obuf_ff <= obuf_in;
   end

endmodule

FILE: hw/rtl/bcf_checker.sv
module bcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // an empty result buffer never blocks input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with no result pending");

   // after reset: nothing pending, input open
   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready && !rsp_tvalid)
      else $error("state not cleared by reset");

endmodule

bind x86_branch_call_filter_core bcf_checker u_bcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
